/* design/bounded_deque_with_remove_core_assert.svh */
// Assertion macros shared by the deque RTL.
// BDQ_ASSERT is disabled while reset is held; BDQ_ASSERT_ALWAYS also checks
// during reset.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/bdq_pkg.sv */
package bdq_pkg;

  // List geometry
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  // Fixed field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_CNT_W  = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_FIND       = 3'd5
  } bdq_req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } bdq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } bdq_state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] value;
  } bdq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [OUT_CNT_W-1:0] entry_count;
  } bdq_res_t;

  // Ring slot of list position pos; the sum stays below twice the depth
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(pos);
    if (sum >= SUM_W'(LIST_DEPTH)) begin
      sum = sum - SUM_W'(LIST_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Entry count as reported in a result
  function automatic logic [OUT_CNT_W-1:0] to_out_count(input logic [CNT_W-1:0] cnt);
    return OUT_CNT_W'(cnt);
  endfunction

endpackage

/* design/bdq_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/bdq_engine.sv */
`include "bounded_deque_with_remove_core_assert.svh"

// Request sequencer: ring pointers, entry memory, scan and shift passes
module bdq_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bdq_pkg::bdq_req_t req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bdq_pkg::bdq_res_t res_o
);

  bdq_pkg::bdq_state_e              state_q, state_d;
  bdq_pkg::bdq_req_t                req_q, req_d;
  bdq_pkg::bdq_status_e             status_q, status_d;
  logic [bdq_pkg::IDX_W-1:0]        front_q, front_d;
  logic [bdq_pkg::CNT_W-1:0]        count_q, count_d;
  logic [bdq_pkg::CNT_W-1:0]        pos_q, pos_d;
  logic [bdq_pkg::CNT_W-1:0]        wr_pos_q, wr_pos_d;
  logic                             pend_q, pend_d;
  logic                             found_q, found_d;

  logic                             accept;
  logic                             empty;
  logic                             full;
  logic                             rd_more;
  logic                             match;
  logic                             rd_en;
  logic                             wr_en;
  logic [bdq_pkg::IDX_W-1:0]        rd_addr;
  logic [bdq_pkg::IDX_W-1:0]        wr_addr;
  logic [bdq_pkg::DATA_W-1:0]       wr_data;
  logic [bdq_pkg::DATA_W-1:0]       rd_data;

  // Status flags
  assign empty       = (count_q == '0);
  assign full        = (count_q == bdq_pkg::FULL_CNT);
  assign rd_more     = (pos_q < count_q);
  assign req_ready_o = (state_q == bdq_pkg::ST_IDLE) && res_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  // Read data arriving now belongs to position pos_q - 1
  assign match       = (state_q == bdq_pkg::ST_SCAN) && pend_q &&
                       (rd_data == $unsigned(req_q.value));

  // Entry memory
  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (bdq_pkg::LIST_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (accept && !empty &&
            (req_i.req_type == bdq_pkg::REQ_REMOVE ||
             req_i.req_type == bdq_pkg::REQ_FIND)) begin
          state_d = bdq_pkg::ST_SCAN;
        end
      end
      bdq_pkg::ST_SCAN: begin
        if (match) begin
          state_d = (req_q.req_type == bdq_pkg::REQ_REMOVE) ? bdq_pkg::ST_SHIFT
                                                             : bdq_pkg::ST_DONE;
        end else if (pend_q && !rd_more) begin
          state_d = bdq_pkg::ST_DONE;
        end
      end
      bdq_pkg::ST_SHIFT: begin
        if (!pend_q) begin
          state_d = bdq_pkg::ST_DONE;
        end
      end
      bdq_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs, memory control and datapath updates
  always_comb begin
    front_d           = front_q;
    count_d           = count_q;
    pos_d             = pos_q;
    wr_pos_d          = wr_pos_q;
    found_d           = found_q;
    status_d          = status_q;
    req_d             = req_q;
    rd_en             = 1'b0;
    rd_addr           = bdq_pkg::slot_of(front_q, pos_q);
    wr_en             = 1'b0;
    wr_addr           = bdq_pkg::slot_of(front_q, wr_pos_q);
    wr_data           = rd_data;
    res_valid_o       = 1'b0;
    res_o.status      = bdq_pkg::STAT_OK;
    res_o.found       = 1'b0;
    res_o.entry_count = bdq_pkg::to_out_count(count_q);

    case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          req_d       = req_i;
          pos_d       = '0;
          found_d     = 1'b0;
          status_d    = bdq_pkg::STAT_OK;
          res_valid_o = 1'b1;
          case (req_i.req_type)
            bdq_pkg::REQ_PUSH_FRONT: begin
              if (full) begin
                res_o.status = bdq_pkg::STAT_FULL;
              end else begin
                front_d = (front_q == '0) ? bdq_pkg::LAST_IDX
                                          : front_q - bdq_pkg::IDX_W'(1);
                wr_en   = 1'b1;
                wr_addr = front_d;
                wr_data = $unsigned(req_i.value);
                count_d = count_q + bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                res_o.status = bdq_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = bdq_pkg::slot_of(front_q, count_q);
                wr_data = $unsigned(req_i.value);
                count_d = count_q + bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_POP_FRONT: begin
              if (empty) begin
                res_o.status = bdq_pkg::STAT_EMPTY;
              end else begin
                front_d = (front_q == bdq_pkg::LAST_IDX) ? '0
                                                         : front_q + bdq_pkg::IDX_W'(1);
                count_d = count_q - bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_POP_BACK: begin
              if (empty) begin
                res_o.status = bdq_pkg::STAT_EMPTY;
              end else begin
                count_d = count_q - bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_REMOVE, bdq_pkg::REQ_FIND: begin
              if (empty) begin
                res_o.status = bdq_pkg::STAT_EMPTY;
              end else begin
                res_valid_o = 1'b0;
              end
            end
            default: begin
              res_o.status = bdq_pkg::STAT_OK;
            end
          endcase
          res_o.entry_count = bdq_pkg::to_out_count(count_d);
        end
      end
      // One read per cycle; each read's data is compared once the registered read data arrives
      bdq_pkg::ST_SCAN: begin
        rd_en = rd_more;
        if (pend_q) begin
          if (match) begin
            found_d  = 1'b1;
            status_d = bdq_pkg::STAT_OK;
            wr_pos_d = pos_q - bdq_pkg::CNT_W'(1);
          end else if (!rd_more) begin
            status_d = bdq_pkg::STAT_NOT_FOUND;
          end
        end
      end
      // Move each later entry one place toward the front; the write trails
      // the read by two positions, so the ports never hit the same entry
      bdq_pkg::ST_SHIFT: begin
        rd_en    = rd_more;
        wr_en    = pend_q;
        wr_pos_d = wr_pos_q + bdq_pkg::CNT_W'(pend_q);
        if (!pend_q) begin
          count_d = count_q - bdq_pkg::CNT_W'(1);
        end
      end
      bdq_pkg::ST_DONE: begin
        res_valid_o       = 1'b1;
        res_o.status      = status_q;
        res_o.found       = found_q;
        res_o.entry_count = bdq_pkg::to_out_count(count_q);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase

    if (rd_en) begin
      pos_d = pos_q + bdq_pkg::CNT_W'(1);
    end
  end

  assign pend_d = rd_en;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Request payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pos_q    <= pos_d;
    wr_pos_q <= wr_pos_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  `BDQ_ASSERT(a_count_bound, count_q <= bdq_pkg::FULL_CNT, "count above depth")
  `BDQ_ASSERT(a_front_bound, front_q <= bdq_pkg::LAST_IDX, "front index out of range")
  `BDQ_ASSERT(a_port_split, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read/write collision")
  `BDQ_ASSERT(a_remove_dec, (state_q == bdq_pkg::ST_SHIFT && !pend_q) |=> (count_q == $past(count_q) - bdq_pkg::CNT_W'(1)), "remove did not shrink list")

endmodule

/* design/bounded_deque_with_remove_core.sv */
// Bounded double-ended queue of signed 32-bit values with find and remove.
// Each request (push front/back, pop front/back, remove first occurrence,
// find) returns one result with status, found flag and entry count. Entries
// live in a 16-deep ring held in a simple dual-port RAM with registered read.
// Pushes, pops, unused request codes and find/remove on an empty list finish
// in the accept cycle and appear on the output in the next cycle. Find scans
// the list front to back through the RAM read port, one entry per cycle.
// A successful remove adds a shift pass that moves each later entry one
// slot forward, one per cycle. One request is in work at a time; the next
// is taken once the result has moved into the output register, which
// holds it while the output is stalled.
module bounded_deque_with_remove_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bdq_pkg::bdq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bdq_pkg::bdq_res_t out_res_o
);

  logic              eng_ready;
  logic              res_valid;
  logic              res_ready;
  bdq_pkg::bdq_res_t res;
  logic              out_valid_q, out_valid_d;
  bdq_pkg::bdq_res_t out_res_q, out_res_d;

  assign in_stall_o = !eng_ready;

  bdq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (eng_ready),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule
